FILE: hdl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Slot count, derived widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int TS_W   = 64;
	localparam int ID_W   = 4;
	localparam int REQ_W  = 3;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [REQ_W-1:0] {
		REQ_START   = 3'd0,
		REQ_RESTART = 3'd1,
		REQ_STOP    = 3'd2,
		REQ_QUERY   = 3'd3,
		REQ_IRQ     = 3'd4
	} req_t;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_RD_DUR  = 12'b0000_0000_0010,
		ST_REM     = 12'b0000_0000_0100,
		ST_SET_EXP = 12'b0000_0000_1000,
		ST_INS_RD  = 12'b0000_0001_0000,
		ST_INS_CMP = 12'b0000_0010_0000,
		ST_INS_PUT = 12'b0000_0100_0000,
		ST_SCH_RD  = 12'b0000_1000_0000,
		ST_SCH_CMP = 12'b0001_0000_0000,
		ST_IRQ_RD  = 12'b0010_0000_0000,
		ST_IRQ_CMP = 12'b0100_0000_0000,
		ST_OUT_FIN = 12'b1000_0000_0000
	} state_t;

endpackage

FILE: hdl/sorted_timer_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Timer slots kept in a queue sorted by expiry, FIFO among ties; start,
// restart, stop, query and expiry interrupt requests, deadline reprogramming.
//
//  Channel | Direction | Handshake         | Content
//  s_*     | in        | tvalid/tready     | one request item
//  m_*     | out       | tvalid/tready     | result items, tlast on the final one
//  cfg_*   | in        | cfg_wr_en         | enabled register
//
// A query or the stop of an idle slot goes straight to the result. Otherwise
// removal scans the queue one entry a cycle, and the sorted insertion reads
// and then compares each entry through the single read port of the expiry
// memory. An interrupt reads and compares the queue head once per expired
// slot. arst_n clears all control state; no clearing pass is needed. A
// stalled output holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// event_id[3:0], duration[67:4], now[131:68], zero fill
	input  logic [stq_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[2:0]
	input  logic [stq_pkg::REQ_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// expired_id[3:0], pending[4], program_deadline[68:5], zero fill
	output logic [stq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// expired_valid[0], program_valid[1]
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data
);
	import stq_pkg::*;

	state_t state_q;

	logic enabled_q;

	// Request registers
	logic [REQ_W-1:0]  req_q;
	logic [SLOT_W-1:0] id_q;
	logic [TS_W-1:0]   dur_q;
	logic [TS_W-1:0]   now_q;
	logic [TS_W-1:0]   exp_q;

	// Queue and slot state
	logic [SLOT_W-1:0] order_q [SLOTS];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  p_q;
	logic [SLOTS-1:0]  active_q;
	logic [SLOTS-1:0]  dur_wr_q;

	// Expiry and duration memories
	logic [TS_W-1:0]   exp_mem [SLOTS];
	logic [TS_W-1:0]   dur_mem [SLOTS];
	logic [TS_W-1:0]   exp_rd_q;
	logic [TS_W-1:0]   dur_rd_q;
	logic [SLOT_W-1:0] exp_raddr;
	logic [SLOT_W-1:0] dur_raddr;
	logic              mem_we;

	// Result staging
	logic              hold_v_q;
	logic [SLOT_W-1:0] hold_id_q;
	logic              res_pend_q;
	logic              res_pv_q;
	logic [TS_W-1:0]   res_dl_q;

	logic              out_v_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]        out_user_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [SLOT_W-1:0] s_id;
	logic              s_bad;
	logic [SLOT_W-1:0] p_idx;
	logic [SLOT_W-1:0] head;
	logic              irq_hit;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_v_q || m_tready;
	assign s_id     = SLOT_W'(s_tdata[3:0]);
	assign s_bad    = (s_tuser > REQ_IRQ) ||
		((s_tuser != REQ_IRQ) && (int'(s_tdata[3:0]) >= SLOTS));
	assign p_idx    = p_q[SLOT_W-1:0];
	assign head     = order_q[0];
	assign irq_hit  = (exp_rd_q <= now_q);

	// The output register is loaded this cycle.
	assign out_load = ((state_q == ST_IRQ_CMP) && irq_hit && hold_v_q && out_free) ||
		((state_q == ST_OUT_FIN) && out_free);

	assign mem_we    = (state_q == ST_SET_EXP);
	assign dur_raddr = s_id;

	always_comb begin
		unique case (state_q)
			ST_INS_RD: exp_raddr = order_q[p_idx];
			default:   exp_raddr = head;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			exp_mem[id_q] <= now_q + dur_q;
			dur_mem[id_q] <= dur_q;
		end
		exp_rd_q <= exp_mem[exp_raddr];
		dur_rd_q <= dur_mem[dur_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_wr_en) begin
			enabled_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			p_q        <= '0;
			active_q   <= '0;
			dur_wr_q   <= '0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			req_q      <= '0;
			id_q       <= '0;
			hold_id_q  <= '0;
			res_pend_q <= 1'b0;
			res_pv_q   <= 1'b0;
		end else begin
			if (out_v_q && m_tready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q      <= s_tuser;
						id_q       <= s_id;
						dur_q      <= s_tdata[67:4];
						now_q      <= s_tdata[131:68];
						p_q        <= '0;
						hold_v_q   <= 1'b0;
						hold_id_q  <= '0;
						res_pend_q <= 1'b0;
						res_pv_q   <= 1'b0;
						res_dl_q   <= '0;
						if (s_bad) begin
							state_q <= ST_OUT_FIN;
						end else begin
							priority case (s_tuser)
								REQ_IRQ:     state_q <= ST_IRQ_RD;
								REQ_RESTART: state_q <= ST_RD_DUR;
								REQ_QUERY: begin
									res_pend_q <= active_q[s_id];
									state_q    <= ST_OUT_FIN;
								end
								default: begin
									// Start and stop go through removal when active.
									if (active_q[s_id]) begin
										state_q <= ST_REM;
									end else if (s_tuser == REQ_STOP) begin
										state_q <= ST_OUT_FIN;
									end else begin
										state_q <= ST_SET_EXP;
									end
								end
							endcase
						end
					end
				end
				ST_RD_DUR: begin
					dur_q   <= dur_wr_q[id_q] ? dur_rd_q : '0;
					state_q <= active_q[id_q] ? ST_REM : ST_SET_EXP;
				end
				ST_REM: begin
					if (order_q[p_idx] == id_q) begin
						for (int i = 0; i < SLOTS - 1; i++) begin
							if (i >= int'(p_q)) begin
								order_q[i] <= order_q[i+1];
							end
						end
						count_q <= count_q - 1'b1;
						p_q     <= '0;
						if (req_q == REQ_STOP) begin
							active_q[id_q] <= 1'b0;
							state_q        <= ST_OUT_FIN;
						end else begin
							state_q <= ST_SET_EXP;
						end
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_SET_EXP: begin
					exp_q          <= now_q + dur_q;
					dur_wr_q[id_q] <= 1'b1;
					active_q[id_q] <= 1'b1;
					p_q            <= '0;
					state_q        <= ST_INS_RD;
				end
				ST_INS_RD: begin
					state_q <= (p_q == count_q) ? ST_INS_PUT : ST_INS_CMP;
				end
				ST_INS_CMP: begin
					// Ties keep going, so the new slot lands behind equal expiries.
					if (exp_q < exp_rd_q) begin
						state_q <= ST_INS_PUT;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_INS_RD;
					end
				end
				ST_INS_PUT: begin
					if (int'(count_q) < SLOTS) begin
						for (int i = 1; i < SLOTS; i++) begin
							if (i > int'(p_q)) begin
								order_q[i] <= order_q[i-1];
							end
						end
						order_q[p_idx] <= id_q;
						count_q        <= count_q + 1'b1;
					end
					state_q <= ST_SCH_RD;
				end
				ST_SCH_RD: begin
					state_q <= ST_SCH_CMP;
				end
				ST_SCH_CMP: begin
					res_pv_q <= enabled_q && (count_q != '0);
					if (enabled_q && (count_q != '0)) begin
						res_dl_q <= (now_q < exp_rd_q) ? exp_rd_q : now_q;
					end else begin
						res_dl_q <= '0;
					end
					state_q <= ST_OUT_FIN;
				end
				ST_IRQ_RD: begin
					state_q <= (count_q == '0) ? ST_SCH_RD : ST_IRQ_CMP;
				end
				ST_IRQ_CMP: begin
					if (!irq_hit) begin
						state_q <= ST_SCH_RD;
					end else if (!hold_v_q || out_free) begin
						// The previous expired slot is known not to be last now.
						if (hold_v_q) begin
							out_v_q    <= 1'b1;
							out_data_q <= {3'b0, 64'b0, 1'b0, 4'(hold_id_q)};
							out_user_q <= 2'b01;
							out_last_q <= 1'b0;
						end
						for (int i = 0; i < SLOTS - 1; i++) begin
							order_q[i] <= order_q[i+1];
						end
						count_q        <= count_q - 1'b1;
						active_q[head] <= 1'b0;
						hold_v_q       <= 1'b1;
						hold_id_q      <= head;
						state_q        <= ST_IRQ_RD;
					end
				end
				ST_OUT_FIN: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_data_q <= {3'b0, res_dl_q, res_pend_q, 4'(hold_id_q)};
						out_user_q <= {res_pv_q, hold_v_q};
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: hdl/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module stq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	// A request owns the sequencer, so no second item is taken right after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while a request was in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_program_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("deadline programmed on a result that is not final");

	a_deadline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[68:5] == 64'd0))
		else $error("deadline nonzero without programming");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue testbench
// Drives timer requests with random idling and a long output hold-off, and
// checks every result item against a behavioral copy of the timer queue.
// ----------------------------------------------------------------------------
module testbench;
	import stq_pkg::*;

class timer_scoreboard;
	logic [63:0]      expiry [SLOTS];
	logic [63:0]      dur_mem [SLOTS];
	bit               active [SLOTS];
	int unsigned      order [$];
	bit               enabled;
	logic [72+2:0]    expected [$];
	int               mismatches;

	function void clear();
		for (int i = 0; i < SLOTS; i++) begin
			expiry[i] = 0;
			dur_mem[i] = 0;
			active[i] = 0;
		end
		order.delete();
		expected.delete();
		enabled = 0;
		mismatches = 0;
	endfunction

	function void unlink(int unsigned id);
		if (!active[id])
			return;
		foreach (order[p])
			if (order[p] == id) begin
				order.delete(p);
				break;
			end
		active[id] = 0;
		expiry[id] = 0;
	endfunction

	// Expected result packed as {last, program_valid, expired_valid, tdata}.
	function void push(bit ev, logic [3:0] id, bit pend, bit pv, logic [63:0] dl, bit lst);
		logic [71:0] d;
		d = '0;
		d[3:0] = id;
		d[4] = pend;
		d[68:5] = dl;
		expected.push_back({lst, pv, ev, d});
	endfunction

	function bit deadline(logic [63:0] now, output logic [63:0] dl);
		logic [63:0] e;
		dl = 0;
		if (!enabled || order.size() == 0)
			return 0;
		e = expiry[order[0]];
		dl = (now < e) ? e : now;
		return 1;
	endfunction

	function void note_request(logic [2:0] req, logic [3:0] id, logic [63:0] dur,
			logic [63:0] now);
		logic [63:0] dl;
		bit pv;
		int k;
		int pos;
		if (req == REQ_IRQ) begin
			k = 0;
			while (order.size() > 0 && expiry[order[0]] <= now) begin
				int unsigned e;
				e = order[0];
				unlink(e);
				push(1, e[3:0], 0, 0, 0, 0);
				k++;
			end
			pv = deadline(now, dl);
			if (k == 0)
				push(0, 0, 0, pv, dl, 1);
			else begin
				logic [74:0] t;
				t = expected.pop_back();
				t[74] = 1;
				t[73] = pv;
				t[68:5] = dl;
				expected.push_back(t);
			end
			return;
		end
		if (req > REQ_IRQ) begin
			push(0, 0, 0, 0, 0, 1);
			return;
		end
		case (req)
			REQ_START, REQ_RESTART: begin
				logic [63:0] d;
				d = (req == REQ_START) ? dur : dur_mem[id];
				unlink(id);
				expiry[id] = now + d;
				dur_mem[id] = d;
				active[id] = 1;
				pos = order.size();
				foreach (order[p])
					if (expiry[id] < expiry[order[p]]) begin
						pos = p;
						break;
					end
				order.insert(pos, id);
				pv = deadline(now, dl);
				push(0, 0, 0, pv, dl, 1);
			end
			REQ_STOP: begin
				unlink(id);
				push(0, 0, 0, 0, 0, 1);
			end
			default: push(0, 0, active[id], 0, 0, 1);
		endcase
	endfunction

	function void check_result(logic [71:0] d, logic [1:0] u, bit lst);
		logic [74:0] got, want;
		got = {lst, u[1], u[0], d};
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result item %h", got);
			return;
		end
		want = expected.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: expected last=%b pv=%b ev=%b id=%0d pend=%b dl=%h,",
					" got last=%b pv=%b ev=%b id=%0d pend=%b dl=%h"},
					want[74], want[73], want[72], want[3:0], want[4], want[68:5],
					got[74], got[73], got[72], got[3:0], got[4], got[68:5]);
		end
	endfunction
endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_wr_en = 0;
	logic                  cfg_wr_data = 0;

	timer_scoreboard queue_model = new();
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_off = 0;
	longint cycles = 0;
	logic [63:0] clock_now = 0;

	sorted_timer_event_queue dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: checks at the edge, then picks tready for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				queue_model.check_result(m_tdata, m_tuser, m_tlast);
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// The item stays offered after acceptance until the next send or drain replaces it.
	task automatic send(logic [2:0] req, logic [3:0] id, logic [63:0] dur, logic [63:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= req;
		s_tdata <= {4'b0, now, dur, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		queue_model.note_request(req, id, dur, now);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (queue_model.expected.size() != 0)
			@(posedge clk);
		repeat (3 * SLOTS + 16) @(posedge clk);
	endtask

	task automatic write_enabled(bit v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		queue_model.enabled = v;
	endtask

	task automatic random_request();
		int r;
		logic [63:0] dur;
		r = $urandom_range(99);
		clock_now = clock_now + 64'($urandom_range(40));
		case ($urandom_range(3))
			0: dur = 64'($urandom_range(60));
			1: dur = 64'($urandom_range(500));
			2: dur = {$urandom, $urandom};
			default: dur = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
		endcase
		if (r < 40)
			send(REQ_START, 4'($urandom_range(15)), dur, clock_now);
		else if (r < 50)
			send(REQ_RESTART, 4'($urandom_range(15)), {$urandom, $urandom}, clock_now);
		else if (r < 60)
			send(REQ_STOP, 4'($urandom_range(15)), {$urandom, $urandom}, clock_now);
		else if (r < 68)
			send(REQ_QUERY, 4'($urandom_range(15)), {$urandom, $urandom}, clock_now);
		else if (r < 94)
			send(REQ_IRQ, 4'($urandom_range(15)), {$urandom, $urandom}, clock_now);
		else if (r < 97)
			send(3'($urandom_range(7, 5)), 4'($urandom_range(15)), {$urandom, $urandom},
				{$urandom, $urandom});
		else begin
			// Jump the clock to a random value before an interrupt request.
			clock_now = {$urandom, $urandom};
			send(REQ_IRQ, 4'($urandom_range(15)), 0, clock_now);
		end
	endtask

	initial begin
		queue_model.clear();
		@(posedge arst_n);
		@(posedge clk);

		// Directed part while disabled, then enabled.
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_START, 0, 100, 10);
		send(REQ_START, 15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send(REQ_IRQ, 0, 0, 200);
		write_enabled(1);
		send(REQ_START, 3, 50, 0);
		send(REQ_START, 4, 50, 0);
		send(REQ_START, 5, 20, 30);
		send(REQ_START, 3, 10, 5);
		send(REQ_QUERY, 4, 0, 0);
		send(REQ_STOP, 4, 0, 0);
		send(REQ_STOP, 4, 0, 0);
		send(REQ_QUERY, 4, 0, 0);
		send(REQ_RESTART, 4, 0, 60);
		send(REQ_RESTART, 9, 0, 1);
		send(REQ_IRQ, 0, 0, 0);
		send(REQ_IRQ, 0, 0, 55);
		send(REQ_IRQ, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE);
		send(REQ_IRQ, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(3'd5, 4'hF, '1, '1);
		send(3'd7, 0, 0, 0);
		send(REQ_IRQ, 0, 0, 0);
		for (int i = 0; i < SLOTS; i++)
			send(REQ_START, 4'(i), 7, 1000);
		send(REQ_IRQ, 0, 0, 1007);
		clock_now = 1007;

		send_idle_pct = 19;
		recv_idle_pct = 58;
		for (int i = 0; i < 62; i++)
			random_request();

		// Output hold-off while the sender keeps offering items.
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++)
				random_request();
		join

		write_enabled(0);
		send_idle_pct = 58;
		recv_idle_pct = 19;
		for (int i = 0; i < 50; i++)
			random_request();

		write_enabled(1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 60; i++)
			random_request();

		drain();
		if (queue_model.mismatches == 0 && queue_model.expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: files.f
hdl/stq_pkg.sv
hdl/sorted_timer_event_queue.sv
hdl/stq_checker.sv
sim/testbench.sv
